[hdl/cdm_pkg.sv]
// Shared types and constants for the color difference matrix.
package cdm_pkg;

  // Matrix mode codes (codes six and seven fall back to pass-through)
  localparam logic [2:0] MODE_YDZDX     = 3'd0;
  localparam logic [2:0] MODE_BT2020    = 3'd1;
  localparam logic [2:0] MODE_BT709     = 3'd2;
  localparam logic [2:0] MODE_YDZDX_100 = 3'd3;
  localparam logic [2:0] MODE_YDZDX_500 = 3'd4;
  localparam logic [2:0] MODE_PASS      = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CODE    = 2'd3;

  localparam int unsigned FIELD_W = 16;

  // Reset values of the registers
  localparam logic [2:0]         RST_MATRIX_MODE = MODE_YDZDX;
  localparam logic [FIELD_W-1:0] RST_HALF_OFFSET = 16'd2048;
  localparam logic [FIELD_W-1:0] RST_MAX_CODE    = 16'd4095;
  localparam logic [FIELD_W-1:0] RST_MIN_CODE    = 16'd0;

  // Q16 rounding constant
  localparam logic [15:0] Q16_HALF = 16'd32768;

  // BT.2020 weights and reciprocals, Q16
  localparam logic [15:0] C2020_R  = 16'd17216;
  localparam logic [15:0] C2020_G  = 16'd44433;
  localparam logic [15:0] C2020_B  = 16'd3886;
  localparam logic [15:0] C2020_RZ = 16'd34834;
  localparam logic [15:0] C2020_RX = 16'd44443;
  // BT.709 weights and reciprocals, Q16
  localparam logic [15:0] C709_R   = 16'd13933;
  localparam logic [15:0] C709_G   = 16'd46871;
  localparam logic [15:0] C709_B   = 16'd4732;
  localparam logic [15:0] C709_RZ  = 16'd35318;
  localparam logic [15:0] C709_RX  = 16'd41615;
  // YDzDx weights, Q16: Dz = Q*B - G/2, Dx = R/2 - S*G
  localparam logic [15:0] W_HALF   = 16'd32768;
  localparam logic [15:0] W100_Q   = 16'd32225;
  localparam logic [15:0] W100_S   = 16'd32437;
  localparam logic [15:0] W500_Q   = 16'd32335;
  localparam logic [15:0] W500_S   = 16'd32507;

  // Datapath flavor carried down the pipeline
  typedef enum logic [1:0] {
    KIND_DIFF,
    KIND_STD,
    KIND_PASS
  } kind_t;

endpackage

[hdl/color_difference_matrix.sv]
// Color difference matrix: G,B,R sample triple in, Y,Dz,Dx out, five-stage pipeline.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-----------------------------------------
//  in_     | in  | in_tvalid / in_tready      | in_tdata:  green_in, blue_in, red_in
//  out_    | out | out_tvalid / out_tready    | out_tdata: luma_out, dz_out, dx_out
//  cfg_    | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data (always ready)
//
// One item per clock sustained while out_tready stays high; each item passes five
// registered stages (input products, luma/difference sums, reciprocal multiply,
// round/truncate, offset and clamp into the output register).
// rst_n is synchronous and clears the valid bits and the configuration registers.
// A stall on out_tready holds each stage that is full and whose successor is full;
// empty stages keep filling, so in_tready drops only once the pipe is packed.
module color_difference_matrix #(
  parameter int unsigned SAMPLE_WIDTH = 16   // 8..16, low bits of each field used
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input samples
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [3*cdm_pkg::FIELD_W-1:0]   in_tdata,   // green_in, blue_in, red_in
  // results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [3*cdm_pkg::FIELD_W-1:0]   out_tdata,  // luma_out, dz_out, dx_out
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cdm_pkg::FIELD_W-1:0]     cfg_data
);

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned FW   = cdm_pkg::FIELD_W;
  localparam int unsigned PW   = SW + 16;        // weight * sample product
  localparam int unsigned DIFW = PW + 1;         // signed Q16 difference
  localparam int unsigned PRW  = DIFW + 17;      // difference * reciprocal
  localparam int unsigned DW   = SW + 2;         // signed difference before offset
  localparam int unsigned AW   = ((DW > FW + 1) ? DW : FW + 1) + 1; // offset/clamp width

  localparam logic signed [PRW-1:0] RND32 = PRW'(64'h0000_0000_8000_0000);
  localparam logic signed [PRW-1:0] MSK32 = PRW'(64'h0000_0000_FFFF_FFFF);
  localparam logic signed [PRW-1:0] MSK16 = PRW'(64'h0000_0000_0000_FFFF);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0]    matrix_mode_r;
  logic [FW-1:0] half_offset_r;
  logic [FW-1:0] max_code_r;
  logic [FW-1:0] min_code_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_mode_r <= cdm_pkg::RST_MATRIX_MODE;
      half_offset_r <= cdm_pkg::RST_HALF_OFFSET;
      max_code_r    <= cdm_pkg::RST_MAX_CODE;
      min_code_r    <= cdm_pkg::RST_MIN_CODE;
    end else if (cfg_valid) begin
      case (cfg_index)
        cdm_pkg::REG_MATRIX_MODE: matrix_mode_r <= cfg_data[2:0];
        cdm_pkg::REG_HALF_OFFSET: half_offset_r <= cfg_data;
        cdm_pkg::REG_MAX_CODE:    max_code_r    <= cfg_data;
        cdm_pkg::REG_MIN_CODE:    min_code_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its successor moves on
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5      = !v5_r || out_tready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pick weights by mode, three sample products
  // Std matrices: products are wr*R, wg*G, wb*B.
  // YDzDx: Q*B, S*G and R/2 (G/2 is a shift, done in stage 2).
  // ---------------------------------------------------------------------------
  logic [SW-1:0] g_in, b_in, r_in;
  logic [15:0]   cb, cg, cr, rz_sel, rx_sel;
  cdm_pkg::kind_t kind_sel;

  assign g_in = in_tdata[SW-1:0];
  assign b_in = in_tdata[FW+SW-1:FW];
  assign r_in = in_tdata[2*FW+SW-1:2*FW];

  always_comb begin
    kind_sel = cdm_pkg::KIND_PASS;
    cb       = '0;
    cg       = '0;
    cr       = '0;
    rz_sel   = '0;
    rx_sel   = '0;
    case (matrix_mode_r)
      cdm_pkg::MODE_YDZDX: begin
        kind_sel = cdm_pkg::KIND_DIFF;
        cb = cdm_pkg::W_HALF;
        cg = cdm_pkg::W_HALF;
        cr = cdm_pkg::W_HALF;
      end
      cdm_pkg::MODE_BT2020: begin
        kind_sel = cdm_pkg::KIND_STD;
        cb = cdm_pkg::C2020_B;
        cg = cdm_pkg::C2020_G;
        cr = cdm_pkg::C2020_R;
        rz_sel = cdm_pkg::C2020_RZ;
        rx_sel = cdm_pkg::C2020_RX;
      end
      cdm_pkg::MODE_BT709: begin
        kind_sel = cdm_pkg::KIND_STD;
        cb = cdm_pkg::C709_B;
        cg = cdm_pkg::C709_G;
        cr = cdm_pkg::C709_R;
        rz_sel = cdm_pkg::C709_RZ;
        rx_sel = cdm_pkg::C709_RX;
      end
      cdm_pkg::MODE_YDZDX_100: begin
        kind_sel = cdm_pkg::KIND_DIFF;
        cb = cdm_pkg::W100_Q;
        cg = cdm_pkg::W100_S;
        cr = cdm_pkg::W_HALF;
      end
      cdm_pkg::MODE_YDZDX_500: begin
        kind_sel = cdm_pkg::KIND_DIFF;
        cb = cdm_pkg::W500_Q;
        cg = cdm_pkg::W500_S;
        cr = cdm_pkg::W_HALF;
      end
      default: kind_sel = cdm_pkg::KIND_PASS;  // pass-through and unused codes
    endcase
  end

  cdm_pkg::kind_t kind1_r;
  logic [SW-1:0]  g1_r, b1_r, r1_r;
  logic [PW-1:0]  mb1_r, mg1_r, mr1_r;
  logic [15:0]    rz1_r, rx1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      kind1_r <= kind_sel;
      g1_r    <= g_in;
      b1_r    <= b_in;
      r1_r    <= r_in;
      mb1_r   <= PW'(cb) * PW'(b_in);
      mg1_r   <= PW'(cg) * PW'(g_in);
      mr1_r   <= PW'(cr) * PW'(r_in);
      rz1_r   <= rz_sel;
      rx1_r   <= rx_sel;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: luma sum t and the two Q16 differences
  // ---------------------------------------------------------------------------
  logic [PW-1:0]          t_sum;
  logic [SW-1:0]          y_nxt2;
  logic signed [DIFW-1:0] dz_nxt2, dx_nxt2;

  always_comb begin
    t_sum   = mr1_r + mg1_r + mb1_r + PW'(cdm_pkg::Q16_HALF);
    y_nxt2  = g1_r;
    dz_nxt2 = '0;
    dx_nxt2 = '0;
    case (kind1_r)
      cdm_pkg::KIND_STD: begin
        y_nxt2  = t_sum[PW-1:16];
        dz_nxt2 = $signed({1'b0, b1_r, 16'd0}) - $signed({1'b0, t_sum});
        dx_nxt2 = $signed({1'b0, r1_r, 16'd0}) - $signed({1'b0, t_sum});
      end
      cdm_pkg::KIND_DIFF: begin
        dz_nxt2 = $signed({1'b0, mb1_r}) - $signed({2'b00, g1_r, 15'd0})
                  + $signed(DIFW'(cdm_pkg::Q16_HALF));
        dx_nxt2 = $signed({1'b0, mr1_r}) - $signed({1'b0, mg1_r})
                  + $signed(DIFW'(cdm_pkg::Q16_HALF));
      end
      default: ;
    endcase
  end

  cdm_pkg::kind_t         kind2_r;
  logic [SW-1:0]          y2_r, b2_r, r2_r;
  logic signed [DIFW-1:0] dz2_r, dx2_r;
  logic [15:0]            rz2_r, rx2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      kind2_r <= kind1_r;
      y2_r    <= y_nxt2;
      b2_r    <= b1_r;
      r2_r    <= r1_r;
      dz2_r   <= dz_nxt2;
      dx2_r   <= dx_nxt2;
      rz2_r   <= rz1_r;
      rx2_r   <= rx1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: reciprocal multiply for the standard matrices (Q32)
  // ---------------------------------------------------------------------------
  logic signed [PRW-1:0] pz_nxt3, px_nxt3;

  always_comb begin
    if (kind2_r == cdm_pkg::KIND_STD) begin
      pz_nxt3 = PRW'(dz2_r) * PRW'($signed({1'b0, rz2_r}));
      px_nxt3 = PRW'(dx2_r) * PRW'($signed({1'b0, rx2_r}));
    end else begin
      pz_nxt3 = {{(PRW-DIFW){dz2_r[DIFW-1]}}, dz2_r};
      px_nxt3 = {{(PRW-DIFW){dx2_r[DIFW-1]}}, dx2_r};
    end
  end

  cdm_pkg::kind_t        kind3_r;
  logic [SW-1:0]         y3_r, b3_r, r3_r;
  logic signed [PRW-1:0] pz3_r, px3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      kind3_r <= kind2_r;
      y3_r    <= y2_r;
      b3_r    <= b2_r;
      r3_r    <= r2_r;
      pz3_r   <= pz_nxt3;
      px3_r   <= px_nxt3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: round, then truncate toward zero
  // Q32 for standard matrices (rounding term added here), Q16 for YDzDx
  // (its rounding term went in at stage 2).
  // ---------------------------------------------------------------------------
  function automatic logic signed [DW-1:0] rnd_trunc(input logic signed [PRW-1:0] v,
                                                      input logic is_q32);
    logic signed [PRW-1:0] w;
    logic signed [PRW-1:0] q;
    if (is_q32) begin
      w = v + RND32;
      w = w[PRW-1] ? w + MSK32 : w;
      q = w >>> 32;
    end else begin
      w = v[PRW-1] ? v + MSK16 : v;
      q = w >>> 16;
    end
    return q[DW-1:0];
  endfunction

  logic signed [DW-1:0] dz_nxt4, dx_nxt4;

  always_comb begin
    case (kind3_r)
      cdm_pkg::KIND_STD: begin
        dz_nxt4 = rnd_trunc(pz3_r, 1'b1);
        dx_nxt4 = rnd_trunc(px3_r, 1'b1);
      end
      cdm_pkg::KIND_DIFF: begin
        dz_nxt4 = rnd_trunc(pz3_r, 1'b0);
        dx_nxt4 = rnd_trunc(px3_r, 1'b0);
      end
      default: begin
        dz_nxt4 = $signed({{(DW-SW){1'b0}}, b3_r});
        dx_nxt4 = $signed({{(DW-SW){1'b0}}, r3_r});
      end
    endcase
  end

  logic [SW-1:0]        y4_r;
  logic signed [DW-1:0] dz4_r, dx4_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      y4_r  <= y3_r;
      dz4_r <= dz_nxt4;
      dx4_r <= dx_nxt4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: Dz/Dx add half_offset - 1 and clamp; luma only clamps to max_code.
  // Max clamp first, then min, so min_code wins when the limits cross.
  // ---------------------------------------------------------------------------
  function automatic logic [FW-1:0] off_clamp(input logic signed [DW-1:0] d,
                                              input logic [FW-1:0] offs,
                                              input logic [FW-1:0] hi,
                                              input logic [FW-1:0] lo);
    logic signed [AW-1:0] s;
    logic signed [AW-1:0] hi_s;
    logic signed [AW-1:0] lo_s;
    s    = {{(AW-DW){d[DW-1]}}, d} + $signed({{(AW-FW){1'b0}}, offs})
           - $signed(AW'(1));
    hi_s = $signed({{(AW-FW){1'b0}}, hi});
    lo_s = $signed({{(AW-FW){1'b0}}, lo});
    if (s > hi_s) s = hi_s;
    if (s < lo_s) s = lo_s;
    return s[FW-1:0];
  endfunction

  logic [FW-1:0] y_ext;
  logic [FW-1:0] luma_nxt, dz_nxt, dx_nxt;

  assign y_ext    = {{(FW-SW){1'b0}}, y4_r};
  assign luma_nxt = (y_ext > max_code_r) ? max_code_r : y_ext;
  assign dz_nxt   = off_clamp(dz4_r, half_offset_r, max_code_r, min_code_r);
  assign dx_nxt   = off_clamp(dx4_r, half_offset_r, max_code_r, min_code_r);

  logic [FW-1:0] luma5_r, dz5_r, dx5_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      luma5_r <= luma_nxt;
      dz5_r   <= dz_nxt;
      dx5_r   <= dx_nxt;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {dx5_r, dz5_r, luma5_r};

endmodule
